>>> rtl/kmerhc_pkg.sv
// Shared constants, codes and controller/datapath interface types for the k-mer counter.
package kmerhc_pkg;

  localparam int MAX_SEQ_LEN_DEF = 8192;
  localparam int MAX_K_DEF       = 8;

  localparam int SYM_W    = 8;
  localparam int IDX_W    = 16;
  localparam int CNT_W    = 16;
  localparam int STATUS_W = 2;
  localparam int K_W      = 4;
  localparam int EPOCH_W  = 8;

  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 4;

  localparam logic [CFG_IDX_W-1:0] CFG_KMER_SIZE = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CLAMP     = 4'd1;

  localparam logic [K_W-1:0] KMER_SIZE_RST = 4'd5;
  localparam logic [K_W-1:0] K_MIN         = 4'd3;

  localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_BAD_SYM   = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_TOO_LONG  = 2'd2;
  localparam logic [STATUS_W-1:0] STATUS_TOO_SHORT = 2'd3;

  localparam logic [SYM_W-1:0] SYM_FIRST = 8'd1;
  localparam logic [SYM_W-1:0] SYM_LAST  = 8'd4;

  localparam logic [CNT_W-1:0] CNT_MAX   = 16'hFFFF;
  localparam logic [CNT_W-1:0] BYTE_MAX  = 16'd255;

  typedef struct packed {
    logic accept;
    logic sweep;
    logic finish;
  } kmerhc_cmd_t;

  typedef struct packed {
    logic wrap_pending;
    logic sweep_last;
    logic out_busy;
  } kmerhc_sts_t;

endpackage

>>> rtl/kmerhc_ctrl.sv
// Controller state machine: table clearing sweep, item acceptance and result hand-off.
module kmerhc_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  kmerhc_pkg::kmerhc_sts_t sts_i,
  output kmerhc_pkg::kmerhc_cmd_t cmd_o
);
  import kmerhc_pkg::*;

  localparam logic [1:0] S_SWEEP = 2'd0;
  localparam logic [1:0] S_IDLE  = 2'd1;
  localparam logic [1:0] S_LOOK  = 2'd2;

  logic [1:0] state_q, state_d;

  always_comb begin
    state_d      = state_q;
    in_stall_o   = 1'b1;
    cmd_o        = '0;
    unique case (state_q)
      S_SWEEP: begin
        cmd_o.sweep = 1'b1;
        if (sts_i.sweep_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        in_stall_o   = sts_i.wrap_pending;
        cmd_o.accept = in_valid_i && !sts_i.wrap_pending;
        if (in_valid_i && sts_i.wrap_pending) begin
          state_d = S_SWEEP;
        end else if (cmd_o.accept) begin
          state_d = S_LOOK;
        end
      end
      S_LOOK: begin
        if (!sts_i.out_busy) begin
          cmd_o.finish = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_SWEEP;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_SWEEP;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

>>> rtl/kmerhc_dp.sv
// Datapath: configuration, rolling window, sequence state, epoch-tagged count table, result register.
module kmerhc_dp #(
  parameter int MAX_SEQ_LEN = kmerhc_pkg::MAX_SEQ_LEN_DEF,
  parameter int MAX_K       = kmerhc_pkg::MAX_K_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  kmerhc_pkg::kmerhc_cmd_t             cmd_i,
  output kmerhc_pkg::kmerhc_sts_t             sts_o,
  input  logic                                cfg_valid_i,
  input  logic [kmerhc_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [kmerhc_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  logic                                mode_i,
  input  logic [kmerhc_pkg::SYM_W-1:0]        symbol_i,
  input  logic                                seq_end_i,
  input  logic [kmerhc_pkg::IDX_W-1:0]        read_index_i,
  input  logic                                out_stall_i,
  output logic                                out_valid_o,
  output logic [kmerhc_pkg::CNT_W-1:0]        count_o,
  output logic [kmerhc_pkg::IDX_W-1:0]        kmer_index_o,
  output logic                                counted_o,
  output logic [kmerhc_pkg::STATUS_W-1:0]     status_o
);
  import kmerhc_pkg::*;

  localparam int AW    = 2 * MAX_K;
  localparam int DEPTH = 1 << AW;
  localparam int DW    = EPOCH_W + CNT_W;
  localparam int SW    = $clog2(MAX_SEQ_LEN + 1);

  logic [K_W-1:0]      kmer_size_q;
  logic                clamp_q;
  logic [AW-1:0]       window_q;
  logic [SW-1:0]       seen_q;
  logic [STATUS_W-1:0] err_q;
  logic                in_seq_q;
  logic [EPOCH_W-1:0]  epoch_q;
  logic [AW-1:0]       sweep_cnt_q;
  logic                out_valid_q;

  logic                mode_q;
  logic [SYM_W-1:0]    sym_q;
  logic                last_q;
  logic [AW-1:0]       addr_q;
  logic [DW-1:0]       rd_q;

  logic [DW-1:0]       mem [DEPTH];

  logic [K_W-1:0]      k_eff;
  logic [AW-1:0]       mask;
  logic [AW-1:0]       win_in;
  logic [AW-1:0]       rd_addr;

  logic                start;
  logic [STATUS_W-1:0] err_b;
  logic [SW-1:0]       seen_b;
  logic [AW-1:0]       win_b;
  logic [EPOCH_W-1:0]  epoch_use;
  logic [CNT_W-1:0]    old_cnt;
  logic [CNT_W-1:0]    inc_cnt;
  logic [SW-1:0]       seen_inc;
  logic                sym_ok;

  logic [CNT_W-1:0]    res_cnt;
  logic [AW-1:0]       res_idx;
  logic                res_counted;
  logic [STATUS_W-1:0] res_status;
  logic [STATUS_W-1:0] err_n;
  logic [SW-1:0]       seen_n;
  logic [AW-1:0]       win_n;
  logic                do_write;

  always_comb begin
    if (kmer_size_q < K_MIN) begin
      k_eff = K_MIN;
    end else if (kmer_size_q > K_W'(MAX_K)) begin
      k_eff = K_W'(MAX_K);
    end else begin
      k_eff = kmer_size_q;
    end
    for (int i = 0; i < AW; i++) begin
      mask[i] = (i < 2 * int'(k_eff));
    end
  end

  assign win_in  = in_seq_q ? window_q : '0;
  assign rd_addr = mode_i ? (read_index_i[AW-1:0] & mask)
                          : ({win_in[AW-3:0], 2'(symbol_i - SYM_FIRST)} & mask);

  assign sts_o.wrap_pending = !mode_i && !in_seq_q && (epoch_q == '1);
  assign sts_o.sweep_last   = (sweep_cnt_q == '1);
  assign sts_o.out_busy     = out_valid_q && out_stall_i;

  // Result of the item in flight
  always_comb begin
    start     = !in_seq_q;
    err_b     = start ? STATUS_OK : err_q;
    seen_b    = start ? '0 : seen_q;
    win_b     = start ? '0 : window_q;
    epoch_use = (!mode_q && start) ? epoch_q + 1'b1 : epoch_q;
    old_cnt   = (rd_q[DW-1 -: EPOCH_W] == epoch_use) ? rd_q[CNT_W-1:0] : '0;
    inc_cnt   = (old_cnt == CNT_MAX) ? old_cnt : old_cnt + 1'b1;
    seen_inc  = seen_b + 1'b1;
    sym_ok    = (sym_q >= SYM_FIRST) && (sym_q <= SYM_LAST);

    res_cnt     = '0;
    res_idx     = '0;
    res_counted = 1'b0;
    res_status  = STATUS_OK;
    err_n       = err_b;
    seen_n      = seen_b;
    win_n       = win_b;
    do_write    = 1'b0;

    if (mode_q) begin
      res_cnt = (clamp_q && old_cnt > BYTE_MAX) ? BYTE_MAX : old_cnt;
    end else if (err_b != STATUS_OK) begin
      res_status = err_b;
    end else if (!sym_ok) begin
      err_n      = STATUS_BAD_SYM;
      res_status = STATUS_BAD_SYM;
    end else if (seen_b >= SW'(MAX_SEQ_LEN)) begin
      err_n      = STATUS_TOO_LONG;
      res_status = STATUS_TOO_LONG;
    end else begin
      win_n  = addr_q;
      seen_n = seen_inc;
      if (last_q && seen_inc <= SW'(k_eff)) begin
        err_n      = STATUS_TOO_SHORT;
        res_status = STATUS_TOO_SHORT;
      end else if (seen_inc >= SW'(k_eff)) begin
        res_cnt     = inc_cnt;
        res_idx     = addr_q;
        res_counted = 1'b1;
        do_write    = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kmer_size_q <= KMER_SIZE_RST;
      clamp_q     <= 1'b0;
      window_q    <= '0;
      seen_q      <= '0;
      err_q       <= STATUS_OK;
      in_seq_q    <= 1'b0;
      epoch_q     <= '0;
      sweep_cnt_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        if (cfg_index_i == CFG_KMER_SIZE) begin
          kmer_size_q <= cfg_data_i[K_W-1:0];
        end else if (cfg_index_i == CFG_CLAMP) begin
          clamp_q <= cfg_data_i[0];
        end
      end
      if (cmd_i.sweep) begin
        sweep_cnt_q <= sweep_cnt_q + 1'b1;
        if (sts_o.sweep_last) begin
          epoch_q <= '0;
        end
      end
      if (cmd_i.finish && !mode_q) begin
        window_q <= win_n;
        seen_q   <= seen_n;
        err_q    <= err_n;
        in_seq_q <= !last_q;
        epoch_q  <= epoch_use;
      end
      if (cmd_i.finish) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      mode_q <= mode_i;
      sym_q  <= symbol_i;
      last_q <= seq_end_i;
      addr_q <= rd_addr;
    end
    if (cmd_i.finish) begin
      count_o      <= res_cnt;
      kmer_index_o <= IDX_W'(res_idx);
      counted_o    <= res_counted;
      status_o     <= res_status;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      rd_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.sweep) begin
      mem[sweep_cnt_q] <= '0;
    end else if (cmd_i.finish && do_write) begin
      mem[addr_q] <= {epoch_use, inc_cnt};
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

>>> rtl/kmer_histogram_counter.sv
// Top level of the streaming DNA k-mer histogram counter.
// An accepted transaction has its operands and table entry registered, and its result is
// registered from the lookup state once the previous result is no longer stalled at the output.
// A new transaction is not taken until the table read-modify-write of the previous one has finished.
// Reset starts a clearing pass over all 4^MAX_K table entries (65536 by default) with input stalled.
// The same pass repeats at the sequence start that would wrap the 8-bit table epoch.
// Configuration writes are taken in every cycle.
module kmer_histogram_counter #(
  parameter int MAX_SEQ_LEN = kmerhc_pkg::MAX_SEQ_LEN_DEF,
  parameter int MAX_K       = kmerhc_pkg::MAX_K_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [kmerhc_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [kmerhc_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic                                mode_i,
  input  logic [kmerhc_pkg::SYM_W-1:0]        symbol_i,
  input  logic                                seq_end_i,
  input  logic [kmerhc_pkg::IDX_W-1:0]        read_index_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [kmerhc_pkg::CNT_W-1:0]        count_o,
  output logic [kmerhc_pkg::IDX_W-1:0]        kmer_index_o,
  output logic                                counted_o,
  output logic [kmerhc_pkg::STATUS_W-1:0]     status_o
);
  import kmerhc_pkg::*;

  kmerhc_cmd_t cmd;
  kmerhc_sts_t sts;

  assign cfg_ready_o = 1'b1;

  kmerhc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  kmerhc_dp #(
    .MAX_SEQ_LEN (MAX_SEQ_LEN),
    .MAX_K       (MAX_K)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .mode_i       (mode_i),
    .symbol_i     (symbol_i),
    .seq_end_i    (seq_end_i),
    .read_index_i (read_index_i),
    .out_stall_i  (out_stall_i),
    .out_valid_o  (out_valid_o),
    .count_o      (count_o),
    .kmer_index_o (kmer_index_o),
    .counted_o    (counted_o),
    .status_o     (status_o)
  );

  a_counted_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && counted_o |-> status_o == STATUS_OK)
    else $error("counted result carries an error status");

  a_idx_only_counted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !counted_o |-> kmer_index_o == '0)
    else $error("k-mer index reported without a count");

  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("second transaction accepted while table update in flight");

  a_sweep_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.sweep |-> in_stall_o && !cmd.finish)
    else $error("transaction taken during table clearing");

endmodule
